// ----- hw/rtl/roi_hsv_pixel_classifier_core_defines.svh -----
// assertion macros for the region pixel classifier
// expects clk and arst_n in the scope where a macro is used
`ifndef ROI_HSV_PIXEL_CLASSIFIER_CORE_DEFINES_SVH
`define ROI_HSV_PIXEL_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define RHPC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhpc assertion failed");

// next-cycle implication
`define RHPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhpc assertion failed");

`endif

// ----- hw/rtl/rhpc_pkg.sv -----
// shared constants and types of the region pixel classifier
// no dependencies
package rhpc_pkg;

	localparam int NUM_TARGETS = 4;
	localparam int COORD_BITS  = 12;
	localparam int NUM_CORNERS = 4;
	localparam logic [7:0] SAT_MIN = 8'd120;

	// working width of coordinate differences and product width
	localparam int DW = 18;
	localparam int PW = 2 * DW;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef enum logic [2:0] {
		REG_VERTEX_0   = 3'd0,
		REG_VERTEX_1   = 3'd1,
		REG_VERTEX_2   = 3'd2,
		REG_VERTEX_3   = 3'd3,
		REG_ROI_ENABLE = 3'd4,
		REG_TARGETS_LO = 3'd5,
		REG_TARGETS_HI = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
	} vertex_t;

	typedef struct packed {
		logic       en;
		logic [7:0] hi;
		logic [7:0] lo;
	} target_t;

endpackage

// ----- hw/rtl/rhpc_if.sv -----
// stream interfaces for pixels in and results out
// depends on rhpc_pkg
interface rhpc_pix_if import rhpc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [7:0]            hue;
	logic [7:0]            saturation;

	modport source (output valid, pixel_x, pixel_y, hue, saturation, input ready);
	modport sink (input valid, pixel_x, pixel_y, hue, saturation, output ready);
endinterface

interface rhpc_res_if ();
	logic       valid;
	logic       ready;
	logic       in_region;
	logic [3:0] target_mask;

	modport source (output valid, in_region, target_mask, input ready);
	modport sink (input valid, in_region, target_mask, output ready);
endinterface

// ----- hw/rtl/rhpc_edge.sv -----
// one polygon edge crossing test over two register stages
// depends on rhpc_pkg; the crossing column is compared by cross-multiplication
module rhpc_edge import rhpc_pkg::*; (
	input  logic                  clk,
	input  logic                  adv,
	input  vertex_t               vtx_a,
	input  vertex_t               vtx_b,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	output logic                  hit
);

	logic signed [DW-1:0] ax, ay, bx, by, sx, sy;
	logic signed [DW-1:0] dy, dd, dyn, dabs, dx, t;
	logic signed [DW-1:0] ymin, ymax, xmax;
	logic                 cond, vert;

	logic                 cond_s1, vert_s1;
	logic signed [DW-1:0] dyn_s1, dx_s1, t_s1, dabs_s1;

	logic                 cond_s2, vert_s2;
	logic signed [PW-1:0] n_s2, td_s2;
	logic signed [DW-1:0] dabs_s2;

	logic signed [PW:0]   n_w, td_w, tdm_w;
	logic                 le;

	// differences and bound checks
	always_comb begin
		ax   = DW'(vtx_a.x);
		ay   = DW'(vtx_a.y);
		bx   = DW'(vtx_b.x);
		by   = DW'(vtx_b.y);
		sx   = $signed({{(DW-COORD_BITS){1'b0}}, px});
		sy   = $signed({{(DW-COORD_BITS){1'b0}}, py});
		ymin = (ay < by) ? ay : by;
		ymax = (ay > by) ? ay : by;
		xmax = (ax > bx) ? ax : bx;
		cond = (sy > ymin) && (sy <= ymax) && (sx <= xmax) && (ay != by);
		vert = (ax == bx);
		dy   = sy - ay;
		dd   = by - ay;
		dyn  = dd[DW-1] ? -dy : dy;
		dabs = dd[DW-1] ? -dd : dd;
		dx   = bx - ax;
		t    = sx - ax;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cond_s1 <= cond;
			vert_s1 <= vert;
			dyn_s1  <= dyn;
			dx_s1   <= dx;
			t_s1    <= t;
			dabs_s1 <= dabs;
		end
	end

	// numerator and scaled column offset
	always_ff @(posedge clk) begin
		if (adv) begin
			cond_s2 <= cond_s1;
			vert_s2 <= vert_s1;
			n_s2    <= dyn_s1 * dx_s1;
			td_s2   <= t_s1 * dabs_s1;
			dabs_s2 <= dabs_s1;
		end
	end

	// column test against the truncated quotient
	always_comb begin
		n_w   = (PW+1)'(n_s2);
		td_w  = (PW+1)'(td_s2);
		tdm_w = td_w - (PW+1)'(dabs_s2);
		le    = n_s2[PW-1] ? (tdm_w < n_w) : (td_w <= n_w);
		hit   = cond_s2 && (vert_s2 || le);
	end

endmodule

// ----- hw/rtl/roi_hsv_pixel_classifier_core.sv -----
// Region pixel classifier: polygon region test and colour target match.
// Three pipeline stages (differences, multiplies, compare) run from pixel transfer
// to result; one pixel per cycle is sustained while results are accepted.
// A stalled result holds the whole pipeline in place.
// Reset clears the configuration registers to 0 (region test off, targets off)
// and empties the pipeline.
`include "roi_hsv_pixel_classifier_core_defines.svh"
module roi_hsv_pixel_classifier_core import rhpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	rhpc_pix_if.sink          pix,
	rhpc_res_if.source        res
);

	vertex_t     vertex_q [NUM_CORNERS];
	logic        roi_enable_q;
	logic [33:0] targets_lo_q;
	logic [33:0] targets_hi_q;

	reg_idx_t    widx;
	logic        wr_en;

	target_t     tgt [4];
	logic [3:0]  mask;
	logic        adv;

	logic        valid_s1, valid_s2;
	logic [3:0]  mask_s1, mask_s2;
	logic [NUM_CORNERS-1:0] hits;
	logic        roi_hit;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel && penable && pwrite;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORNERS; i++) vertex_q[i] <= '0;
			roi_enable_q <= 1'b0;
			targets_lo_q <= '0;
			targets_hi_q <= '0;
		end else if (wr_en) begin
			case (widx)
				REG_VERTEX_0:   vertex_q[0] <= pwdata[31:0];
				REG_VERTEX_1:   vertex_q[1] <= pwdata[31:0];
				REG_VERTEX_2:   vertex_q[2] <= pwdata[31:0];
				REG_VERTEX_3:   vertex_q[3] <= pwdata[31:0];
				REG_ROI_ENABLE: roi_enable_q <= pwdata[0];
				REG_TARGETS_LO: targets_lo_q <= pwdata[33:0];
				REG_TARGETS_HI: targets_hi_q <= pwdata[33:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (widx)
			REG_VERTEX_0:   prdata = DATA_W'(vertex_q[0]);
			REG_VERTEX_1:   prdata = DATA_W'(vertex_q[1]);
			REG_VERTEX_2:   prdata = DATA_W'(vertex_q[2]);
			REG_VERTEX_3:   prdata = DATA_W'(vertex_q[3]);
			REG_ROI_ENABLE: prdata = DATA_W'(roi_enable_q);
			REG_TARGETS_LO: prdata = DATA_W'(targets_lo_q);
			REG_TARGETS_HI: prdata = DATA_W'(targets_hi_q);
			default:        prdata = '0;
		endcase
	end

	// pipeline advances unless a result waits
	assign adv       = !res.valid || res.ready;
	assign pix.ready = adv;

	// colour target match
	always_comb begin
		tgt[0] = targets_lo_q[16:0];
		tgt[1] = targets_lo_q[33:17];
		tgt[2] = targets_hi_q[16:0];
		tgt[3] = targets_hi_q[33:17];
		mask   = '0;
		for (int n = 0; n < NUM_TARGETS; n++) begin
			mask[n] = tgt[n].en && (pix.hue > tgt[n].lo) && (pix.hue < tgt[n].hi)
				&& (pix.saturation > SAT_MIN);
		end
	end

	// edge units
	for (genvar e = 0; e < NUM_CORNERS; e++) begin : g_edge
		rhpc_edge u_edge (
			.clk   (clk),
			.adv   (adv),
			.vtx_a (vertex_q[e]),
			.vtx_b (vertex_q[(e + 1) % NUM_CORNERS]),
			.px    (pix.pixel_x),
			.py    (pix.pixel_y),
			.hit   (hits[e])
		);
	end

	assign roi_hit = !roi_enable_q || (^hits);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			res.valid <= 1'b0;
		end else if (adv) begin
			valid_s1  <= pix.valid;
			valid_s2  <= valid_s1;
			res.valid <= valid_s2;
		end
	end

	// payload stages and output register
	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s1         <= mask;
			mask_s2         <= mask_s1;
			res.in_region   <= roi_hit;
			res.target_mask <= roi_hit ? mask_s2 : 4'd0;
		end
	end

	`RHPC_ASSERT_NEXT(a_enter, pix.valid && pix.ready, valid_s1)
	`RHPC_ASSERT_IMPL(a_roi_off, res.valid && !roi_enable_q && $stable(roi_enable_q), res.in_region)
	`RHPC_ASSERT_IMPL(a_outside_mask, res.valid && !res.in_region, res.target_mask == 4'd0)
	`RHPC_ASSERT_NEXT(a_stall_hold, res.valid && !res.ready, $stable(valid_s2) && $stable(valid_s1))

endmodule
